[sv/smmr_pkg.sv]
// Shared widths and the histogram command bundle of the state map mode rescaler.
`timescale 1ns / 1ps

package smmr_pkg;

   // Default configuration limits.
   localparam int STATE_COUNT_DEF = 16;
   localparam int MAX_SOURCE_DEF  = 65536;
   localparam int MAX_TARGET_DEF  = 8192;

   // Field widths fixed by the interface.
   localparam int CODE_W    = 8;
   localparam int STATE_W   = 4;
   localparam int SRC_LEN_W = 17;
   localparam int TGT_LEN_W = 14;
   localparam int GRP_IDX_W = 13;
   localparam int HIST_W    = 17;

   // Longest run of results that one request may produce.
   localparam int RUN_LIMIT = 64;
   localparam int RUN_W     = 7;

   // Command bundle from the sequencer to the histogram store.
   typedef struct packed {
      logic               count_en;
      logic [STATE_W-1:0] count_addr;
      logic               clear_en;
      logic [STATE_W-1:0] clear_addr;
      logic               scan_start;
   } hist_cmd_type;

endpackage

[sv/smmr_hist.sv]
// Histogram store: one-port-read memory with saturating update, forwarding and argmax scan.
`timescale 1ns / 1ps

module smmr_hist #(
   parameter int STATE_COUNT = smmr_pkg::STATE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smmr_pkg::hist_cmd_type        hist_cmd,
   output logic [smmr_pkg::STATE_W-1:0]  winner
);
   import smmr_pkg::*;

   localparam int ADDR_W = $clog2(STATE_COUNT);
   localparam logic [HIST_W-1:0] HIST_MAX = '1;

   logic [HIST_W-1:0] hist_mem [STATE_COUNT];
   logic [HIST_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   logic              upd_pend_ff;
   logic [ADDR_W-1:0] upd_addr_ff;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [HIST_W-1:0] fwd_data_ff;
   logic              cmp_pend_ff;
   logic [ADDR_W-1:0] cmp_addr_ff;
   logic [HIST_W-1:0] best_ff;
   logic [ADDR_W-1:0] win_ff;

   logic [HIST_W-1:0] cur_count;
   logic [HIST_W-1:0] upd_count;

   assign rd_addr = hist_cmd.clear_en ? hist_cmd.clear_addr[ADDR_W-1:0]
                                      : hist_cmd.count_addr[ADDR_W-1:0];

   // The update written at the same edge as this read is forwarded in place of the stale data.
   assign cur_count = (fwd_valid_ff && (fwd_addr_ff == upd_addr_ff)) ? fwd_data_ff
                                                                     : rd_data_ff;
   assign upd_count = (cur_count == HIST_MAX) ? cur_count : cur_count + 1'b1;

   assign winner = STATE_W'(win_ff);

   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[rd_addr];
      if (upd_pend_ff) begin
         hist_mem[upd_addr_ff] <= upd_count;
      end else if (hist_cmd.clear_en) begin
         hist_mem[hist_cmd.clear_addr[ADDR_W-1:0]] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_pend_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         cmp_pend_ff  <= 1'b0;
      end else begin
         upd_pend_ff  <= hist_cmd.count_en;
         fwd_valid_ff <= upd_pend_ff;
         cmp_pend_ff  <= hist_cmd.clear_en;
      end
      upd_addr_ff <= hist_cmd.count_addr[ADDR_W-1:0];
      fwd_addr_ff <= upd_addr_ff;
      fwd_data_ff <= upd_count;
      cmp_addr_ff <= hist_cmd.clear_addr[ADDR_W-1:0];
      // Ascending scan with >= so that ties go to the higher state.
      if (hist_cmd.scan_start) begin
         best_ff <= '0;
         win_ff  <= '0;
      end else if (cmp_pend_ff && (rd_data_ff >= best_ff)) begin
         best_ff <= rd_data_ff;
         win_ff  <= cmp_addr_ff;
      end
   end

endmodule

[sv/state_map_mode_rescaler.sv]
// Top level of the state map mode rescaler: register port, divider, sequencer and output stage.
`timescale 1ns / 1ps

// Each request carries one source cell code; the block returns the display map cell by cell.
// With equal lengths a request gives one response and one request is taken per cycle while the
// output is not stalled. When scaling up, a request gives ratio responses (the last cell of a
// pass also the padding), at most 64, one per cycle from the output register while it is not
// stalled. When scaling down, a request is taken per cycle within a group; the histogram update
// is a read-modify-write of the memory with forwarding. At the end of each group the memory is
// scanned one entry per cycle through its single read port, and the settle, scan, final and
// post states pass before the winner leaves and the next request is taken. After reset and
// after every register write the block derives the mode and then the ratio in a bit-serial
// divider, and clears the histogram memory in the same pass; no request is taken meanwhile.

module state_map_mode_rescaler #(
   parameter int STATE_COUNT = smmr_pkg::STATE_COUNT_DEF,
   parameter int MAX_SOURCE  = smmr_pkg::MAX_SOURCE_DEF,
   parameter int MAX_TARGET  = smmr_pkg::MAX_TARGET_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [smmr_pkg::CODE_W-1:0]  req_cell_code,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [smmr_pkg::STATE_W-1:0] rsp_cell_state,
   output logic                         rsp_run_last,
   output logic                         rsp_truncated,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [2:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import smmr_pkg::*;

   localparam int ADDR_W    = $clog2(STATE_COUNT);
   localparam int DIV_STEPS = SRC_LEN_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam logic [SRC_LEN_W-1:0] SRC_CAP =
      SRC_LEN_W'((MAX_SOURCE > (2 ** SRC_LEN_W) - 1) ? (2 ** SRC_LEN_W) - 1 : MAX_SOURCE);
   localparam logic [TGT_LEN_W-1:0] TGT_CAP =
      TGT_LEN_W'((MAX_TARGET > (2 ** TGT_LEN_W) - 1) ? (2 ** TGT_LEN_W) - 1 : MAX_TARGET);

   localparam logic REG_SOURCE_LENGTH = 1'b0;
   localparam logic REG_TARGET_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_UP   = 2'd1,
      MODE_DOWN = 2'd2
   } scale_mode_type;

   typedef enum logic [6:0] {
      S_LOAD   = 7'b0000001,
      S_DIV    = 7'b0000010,
      S_RUN    = 7'b0000100,
      S_SETTLE = 7'b0001000,
      S_SCAN   = 7'b0010000,
      S_FINAL  = 7'b0100000,
      S_POST   = 7'b1000000
   } seq_state_type;

   seq_state_type          state_ff, state_in;
   scale_mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SRC_LEN_W-1:0]   src_len_ff, src_len_in;
   logic [TGT_LEN_W-1:0]   tgt_len_ff, tgt_len_in;
   logic [SRC_LEN_W-1:0]   ratio_ff, ratio_in;
   logic [TGT_LEN_W-1:0]   last_cnt_ff, last_cnt_in;
   logic [SRC_LEN_W-1:0]   num_ff, num_in;
   logic [SRC_LEN_W-1:0]   rem_ff, rem_in;
   logic [SRC_LEN_W-1:0]   dvs_ff, dvs_in;
   logic [SRC_LEN_W-1:0]   src_idx_ff, src_idx_in;
   logic [GRP_IDX_W-1:0]   grp_idx_ff, grp_idx_in;
   logic [SRC_LEN_W-1:0]   grp_fill_ff, grp_fill_in;
   logic [RUN_W-1:0]       run_left_ff, run_left_in;
   logic [STATE_W-1:0]     run_state_ff, run_state_in;
   logic                   run_trunc_ff, run_trunc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]     rsp_state_ff, rsp_state_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_trunc_ff, rsp_trunc_in;

   hist_cmd_type           hist_cmd;
   logic [STATE_W-1:0]     winner;

   logic                   cfg_we;
   logic [SRC_LEN_W-1:0]   src_wr;
   logic [TGT_LEN_W-1:0]   tgt_wr;
   logic                   req_take;
   logic                   code_ok;
   logic                   last_cell;
   logic                   out_free;
   logic                   push_run;
   logic [SRC_LEN_W:0]     div_trial;
   logic                   div_ge;
   logic [SRC_LEN_W-1:0]   div_rem;
   logic [SRC_LEN_W-1:0]   div_num;
   logic [SRC_LEN_W-1:0]   run_count;
   logic [SRC_LEN_W-1:0]   fill_next;

   smmr_hist #(
      .STATE_COUNT (STATE_COUNT)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .hist_cmd (hist_cmd),
      .winner   (winner)
   );

   assign cfg_we     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SOURCE_LENGTH) ? 32'(src_len_ff)
                                                            : 32'(tgt_len_ff);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_state = rsp_state_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_truncated  = rsp_trunc_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign push_run  = (state_ff == S_RUN) && (run_left_ff != '0) && out_free;
   assign code_ok   = {1'b0, req_cell_code} < (CODE_W + 1)'(STATE_COUNT);
   assign last_cell = ({1'b0, src_idx_ff} + 1'b1) >= {1'b0, src_len_ff};
   assign fill_next = grp_fill_ff + 1'b1;

   // A new run may load in the cycle that the old one sends its final response.
   always_comb begin
      req_ready = 1'b0;
      if (state_ff == S_RUN) begin
         if (mode_ff == MODE_DOWN) begin
            req_ready = 1'b1;
         end else begin
            req_ready = (run_left_ff == '0) || ((run_left_ff == RUN_W'(1)) && out_free);
         end
      end
   end
   assign req_take = req_valid && req_ready;

   // One restoring division step per cycle.
   assign div_trial = {rem_ff, num_ff[SRC_LEN_W-1]};
   assign div_ge    = div_trial >= {1'b0, dvs_ff};
   assign div_rem   = div_ge ? SRC_LEN_W'(div_trial - {1'b0, dvs_ff})
                             : div_trial[SRC_LEN_W-1:0];
   assign div_num   = {num_ff[SRC_LEN_W-2:0], div_ge};

   always_comb begin
      unique case (mode_ff)
         MODE_UP:   run_count = last_cell ? SRC_LEN_W'(last_cnt_ff) : ratio_ff;
         MODE_PASS: run_count = SRC_LEN_W'(1);
         default:   run_count = SRC_LEN_W'(1);
      endcase
   end

   assign src_wr = csr_pwdata[SRC_LEN_W-1:0];
   assign tgt_wr = csr_pwdata[TGT_LEN_W-1:0];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      src_len_in   = src_len_ff;
      tgt_len_in   = tgt_len_ff;
      ratio_in     = ratio_ff;
      last_cnt_in  = last_cnt_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      src_idx_in   = src_idx_ff;
      grp_idx_in   = grp_idx_ff;
      grp_fill_in  = grp_fill_ff;
      run_left_in  = run_left_ff;
      run_state_in = run_state_ff;
      run_trunc_in = run_trunc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_state_in = rsp_state_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;

      hist_cmd.count_en   = 1'b0;
      hist_cmd.count_addr = '0;
      hist_cmd.clear_en   = 1'b0;
      hist_cmd.clear_addr = STATE_W'(cnt_ff[ADDR_W-1:0]);
      hist_cmd.scan_start = 1'b0;

      if (push_run) begin
         rsp_valid_in = 1'b1;
         rsp_state_in = run_state_ff;
         rsp_last_in  = (run_left_ff == RUN_W'(1));
         rsp_trunc_in = run_trunc_ff;
         run_left_in  = run_left_ff - 1'b1;
      end

      unique case (state_ff)
         S_LOAD: begin
            rem_in = '0;
            cnt_in = '0;
            if (SRC_LEN_W'(tgt_len_ff) == src_len_ff) begin
               mode_in = MODE_PASS;
               num_in  = src_len_ff;
               dvs_in  = src_len_ff;
            end else if (SRC_LEN_W'(tgt_len_ff) > src_len_ff) begin
               mode_in = MODE_UP;
               num_in  = SRC_LEN_W'(tgt_len_ff);
               dvs_in  = src_len_ff;
            end else begin
               mode_in = MODE_DOWN;
               num_in  = src_len_ff;
               dvs_in  = SRC_LEN_W'(tgt_len_ff);
            end
            state_in = S_DIV;
         end
         S_DIV: begin
            num_in = div_num;
            rem_in = div_rem;
            cnt_in = cnt_ff + 1'b1;
            // The histogram is cleared while the divider runs.
            hist_cmd.clear_en = cnt_ff < CNT_W'(STATE_COUNT);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               ratio_in = (mode_ff == MODE_PASS) ? SRC_LEN_W'(1) : div_num;
               // The last source cell of an up-scale pass covers quotient plus remainder.
               last_cnt_in = TGT_LEN_W'(div_num) + TGT_LEN_W'(div_rem);
               state_in    = S_RUN;
            end
         end
         S_RUN: begin
            if (req_take) begin
               if (mode_ff == MODE_DOWN) begin
                  hist_cmd.count_en   = code_ok;
                  hist_cmd.count_addr = code_ok ? req_cell_code[STATE_W-1:0] : '0;
                  if (last_cell) begin
                     src_idx_in  = '0;
                     grp_idx_in  = '0;
                     grp_fill_in = '0;
                     state_in    = S_SETTLE;
                  end else if ((({1'b0, grp_idx_ff} + 1'b1) < tgt_len_ff) &&
                               (fill_next >= ratio_ff)) begin
                     src_idx_in  = src_idx_ff + 1'b1;
                     grp_idx_in  = grp_idx_ff + 1'b1;
                     grp_fill_in = '0;
                     state_in    = S_SETTLE;
                  end else begin
                     src_idx_in  = src_idx_ff + 1'b1;
                     grp_fill_in = fill_next;
                  end
               end else begin
                  run_state_in = code_ok ? req_cell_code[STATE_W-1:0] : '0;
                  run_trunc_in = run_count > SRC_LEN_W'(RUN_LIMIT);
                  run_left_in  = (run_count > SRC_LEN_W'(RUN_LIMIT)) ? RUN_W'(RUN_LIMIT)
                                                                    : run_count[RUN_W-1:0];
                  src_idx_in   = last_cell ? '0 : src_idx_ff + 1'b1;
               end
            end
         end
         S_SETTLE: begin
            // The last count lands in memory this cycle; the scan reads after it.
            hist_cmd.scan_start = 1'b1;
            cnt_in              = '0;
            state_in            = S_SCAN;
         end
         S_SCAN: begin
            hist_cmd.clear_en = 1'b1;
            cnt_in            = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STATE_COUNT - 1)) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            state_in = S_POST;
         end
         S_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = winner;
               rsp_last_in  = 1'b1;
               rsp_trunc_in = 1'b0;
               state_in     = S_RUN;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // Any register write restarts the pass and derives mode and ratio again.
      if (cfg_we) begin
         if (csr_paddr[2] == REG_TARGET_LENGTH) begin
            tgt_len_in = (tgt_wr == '0) ? TGT_LEN_W'(1)
                                        : ((tgt_wr > TGT_CAP) ? TGT_CAP : tgt_wr);
         end else begin
            src_len_in = (src_wr == '0) ? SRC_LEN_W'(1)
                                        : ((src_wr > SRC_CAP) ? SRC_CAP : src_wr);
         end
         src_idx_in  = '0;
         grp_idx_in  = '0;
         grp_fill_in = '0;
         run_left_in = '0;
         state_in    = S_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         mode_ff      <= MODE_PASS;
         cnt_ff       <= '0;
         src_len_ff   <= SRC_LEN_W'(1);
         tgt_len_ff   <= TGT_LEN_W'(1);
         ratio_ff     <= SRC_LEN_W'(1);
         src_idx_ff   <= '0;
         grp_idx_ff   <= '0;
         grp_fill_ff  <= '0;
         run_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         src_len_ff   <= src_len_in;
         tgt_len_ff   <= tgt_len_in;
         ratio_ff     <= ratio_in;
         src_idx_ff   <= src_idx_in;
         grp_idx_ff   <= grp_idx_in;
         grp_fill_ff  <= grp_fill_in;
         run_left_ff  <= run_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_cnt_ff  <= last_cnt_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      run_state_ff <= run_state_in;
      run_trunc_ff <= run_trunc_in;
      rsp_state_ff <= rsp_state_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

endmodule
